>>> design/dtc_pkg.sv
package dtc_pkg;

  localparam int unsigned ActionWidth  = 2;
  localparam int unsigned DataWidth    = 8;
  localparam int unsigned DividerWidth = 16;
  localparam int unsigned CounterWidth = 8;
  localparam int unsigned SelWidth     = 2;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 8;
  localparam int unsigned BitIdxWidth  = 4;

  localparam logic [DividerWidth-1:0] TICK_STEP = DividerWidth'(4);
  localparam logic [CounterWidth-1:0] COUNTER_MAX = {CounterWidth{1'b1}};

  localparam logic [BitIdxWidth-1:0] SEL_BIT [4] = '{4'd9, 4'd3, 4'd5, 4'd7};

  typedef enum logic [ActionWidth-1:0] {
    ACT_TICK   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_DIVRST = 2'd2,
    ACT_NOP    = 2'd3
  } dtc_action_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TIMER_ENABLE = 2'd0,
    CFG_CLOCK_SELECT = 2'd1,
    CFG_RELOAD_VALUE = 2'd2
  } dtc_cfg_idx_t;

  typedef struct packed {
    logic                    timer_enable;
    logic [SelWidth-1:0]     clock_select;
    logic [CounterWidth-1:0] reload_value;
  } dtc_cfg_t;

  typedef struct packed {
    logic [DataWidth-1:0]    divider_high;
    logic [CounterWidth-1:0] counter_value;
    logic                    timer_interrupt;
  } dtc_result_t;

endpackage

>>> design/dtc_if.sv
interface dtc_in_if import dtc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ActionWidth-1:0] action;
  logic [DataWidth-1:0]   write_data;

  modport source (output valid, action, write_data, input ready);
  modport sink (input valid, action, write_data, output ready);
endinterface

interface dtc_out_if import dtc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DataWidth-1:0]    divider_high;
  logic [CounterWidth-1:0] counter_value;
  logic                    timer_interrupt;

  modport source (output valid, divider_high, counter_value, timer_interrupt, input ready);
  modport sink (input valid, divider_high, counter_value, timer_interrupt, output ready);
endinterface

>>> design/dtc_cfg_regs.sv
module dtc_cfg_regs
  import dtc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output dtc_cfg_t                cfg
);

  dtc_cfg_t cfg_r;
  dtc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (dtc_cfg_idx_t'(cfg_index))
        CFG_TIMER_ENABLE: cfg_nxt.timer_enable = cfg_data[0];
        CFG_CLOCK_SELECT: cfg_nxt.clock_select = cfg_data[SelWidth-1:0];
        CFG_RELOAD_VALUE: cfg_nxt.reload_value = cfg_data[CounterWidth-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/dtc_timer_core.sv
module dtc_timer_core
  import dtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [ActionWidth-1:0] action,
  input  logic [DataWidth-1:0] write_data,
  input  dtc_cfg_t             cfg,
  output dtc_result_t          result
);

  logic [DividerWidth-1:0] div_r, div_nxt;
  logic [DividerWidth-1:0] prev_div_r, prev_div_nxt;
  logic [CounterWidth-1:0] counter_r, counter_nxt;
  logic [DividerWidth-1:0] div_inc;
  logic [BitIdxWidth-1:0]  sel_idx;
  logic                    fall_edge;
  logic                    irq;

  assign div_inc   = div_r + TICK_STEP;
  assign sel_idx   = SEL_BIT[cfg.clock_select];
  assign fall_edge = prev_div_r[sel_idx] && !div_inc[sel_idx];

  always_comb begin
    div_nxt      = div_r;
    prev_div_nxt = prev_div_r;
    counter_nxt  = counter_r;
    irq          = 1'b0;
    case (dtc_action_t'(action))
      ACT_TICK: begin
        div_nxt      = div_inc;
        prev_div_nxt = div_inc;
        if (cfg.timer_enable && fall_edge) begin
          if (counter_r == COUNTER_MAX) begin
            counter_nxt = cfg.reload_value;
            irq         = 1'b1;
          end else begin
            counter_nxt = counter_r + CounterWidth'(1);
          end
        end
      end
      ACT_WRITE: begin
        counter_nxt = write_data;
      end
      ACT_DIVRST: begin
        div_nxt = '0;
      end
      default: begin
        div_nxt = div_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r      <= '0;
      prev_div_r <= '0;
      counter_r  <= '0;
    end else if (step_en) begin
      div_r      <= div_nxt;
      prev_div_r <= prev_div_nxt;
      counter_r  <= counter_nxt;
    end
  end

  assign result.divider_high    = div_nxt[DividerWidth-1 -: DataWidth];
  assign result.counter_value   = counter_nxt;
  assign result.timer_interrupt = irq;

  a_tick_tracks_prev: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && action == ACT_TICK |=> prev_div_r == div_r)
    else $error("previous divider does not follow divider after a tick");

  a_divrst_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && action == ACT_DIVRST |=> div_r == '0 && $stable(prev_div_r))
    else $error("divider reset did not clear divider or touched previous divider");

  a_irq_cause: assert property (@(posedge clk) disable iff (!rst_n)
    irq |-> action == ACT_TICK && cfg.timer_enable && counter_r == COUNTER_MAX)
    else $error("interrupt without counter overflow");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(div_r) && $stable(counter_r) && $stable(prev_div_r))
    else $error("timer state changed without an item");

endmodule

>>> design/divider_timer_counter.sv
// Path: an accepted item waits in the input register; its result is loaded into the result
// register, which drives the output. While out_ch.ready is low with a result pending, both
// registers hold their items.
// Throughput: one item per cycle; a new item is taken whenever the input register is empty
// or its item moves into the result register in the same cycle.
// Reset: synchronous, active low; clears divider, previous divider, counter, configuration
// registers and both valid flags.
module divider_timer_counter
  import dtc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  dtc_in_if.sink                  in_ch,
  dtc_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  dtc_cfg_t               cfg;
  dtc_result_t            step_result;
  logic                   in_valid_r;
  logic [ActionWidth-1:0] in_action_r;
  logic [DataWidth-1:0]   in_data_r;
  logic                   out_valid_r;
  dtc_result_t            out_r;
  logic                   out_load;
  logic                   in_load;

  assign out_load = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || out_load;
  assign in_load = in_ch.valid && in_ch.ready;

  dtc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dtc_timer_core u_timer_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (out_load),
    .action     (in_action_r),
    .write_data (in_data_r),
    .cfg        (cfg),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (!out_valid_r || out_ch.ready) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_action_r <= in_ch.action;
      in_data_r   <= in_ch.write_data;
    end
    if (out_load) begin
      out_r <= step_result;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.divider_high    = out_r.divider_high;
  assign out_ch.counter_value   = out_r.counter_value;
  assign out_ch.timer_interrupt = out_r.timer_interrupt;

endmodule
